// ----- design/opp_pkg.sv -----
// Shared types, codes and constants for the omnidirectional point projection block.
package opp_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int COEFF_TERMS_DEF      = 20;
  localparam int ANGLE_ITERATIONS_DEF = 24;

  // Counter width and fixed step counts of the iterative units.
  localparam int STEP_W     = 6;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 63;

  // Request operation codes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_AFFINE_C   = 3'd0;
  localparam logic [2:0] REG_AFFINE_D   = 3'd1;
  localparam logic [2:0] REG_AFFINE_E   = 3'd2;
  localparam logic [2:0] REG_CENTER_COL = 3'd3;
  localparam logic [2:0] REG_CENTER_ROW = 3'd4;

  // Input request payload.
  typedef struct packed {
    logic               op;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } opp_in_t;

  // Result payload.
  typedef struct packed {
    logic signed [31:0] pixel_col;
    logic signed [31:0] pixel_row;
    logic               valid_res;
  } opp_out_t;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [31:0] affine_c;
    logic signed [31:0] affine_d;
    logic signed [31:0] affine_e;
    logic [28:0]        center_col;
    logic [28:0]        center_row;
  } opp_cfg_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_SQX,
    DP_SQY,
    DP_SQSUM,
    DP_SQRT,
    DP_CINIT,
    DP_CORDIC,
    DP_HINIT,
    DP_HMUL,
    DP_HADD,
    DP_XMUL,
    DP_YMUL,
    DP_DPREP,
    DP_DIV,
    DP_XDONE,
    DP_YDONE,
    DP_CMUL,
    DP_DMUL,
    DP_EMUL,
    DP_COL,
    DP_ROW,
    DP_OUT
  } dp_op_t;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_t            op;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic norm_zero;
  } dp_stat_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQSUM,
    ST_SQRT,
    ST_CHECK,
    ST_CORDIC,
    ST_HINIT,
    ST_HMUL,
    ST_HADD,
    ST_XMUL,
    ST_XPREP,
    ST_XDIV,
    ST_XDONE,
    ST_YMUL,
    ST_YPREP,
    ST_YDIV,
    ST_YDONE,
    ST_CMUL,
    ST_DMUL,
    ST_EMUL,
    ST_COL,
    ST_ROW,
    ST_DONE
  } ctl_state_t;

  // Arctangent of 2^-i in Q2.30, truncated.
  function automatic logic [31:0] atan_f(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- design/opp_ctrl.sv -----
// Sequencer for the projection block: steps the datapath through one request.
module opp_ctrl #(
  parameter int COEFF_TERMS      = opp_pkg::COEFF_TERMS_DEF,
  parameter int ANGLE_ITERATIONS = opp_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output opp_pkg::dp_cmd_t cmd,
  input  opp_pkg::dp_stat_t stat
);
  import opp_pkg::*;

  ctl_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result register can take a new result when empty or being drained.
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_op == OP_PROJECT) state_nxt = ST_SQX;
      end
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_SQSUM;
      ST_SQSUM: begin
        state_nxt = ST_SQRT;
        cnt_nxt   = '0;
      end
      ST_SQRT: begin
        if (cnt_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = ST_CHECK;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_CHECK: begin
        cnt_nxt = '0;
        if (stat.norm_zero) state_nxt = ST_DONE;
        else state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cnt_r == STEP_W'(ANGLE_ITERATIONS - 1)) state_nxt = ST_HINIT;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_HINIT: begin
        if (COEFF_TERMS > 1) begin
          state_nxt = ST_HMUL;
          cnt_nxt   = STEP_W'(COEFF_TERMS - 2);
        end else begin
          state_nxt = ST_XMUL;
        end
      end
      ST_HMUL: state_nxt = ST_HADD;
      ST_HADD: begin
        if (cnt_r == '0) state_nxt = ST_XMUL;
        else begin
          state_nxt = ST_HMUL;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      ST_XMUL: state_nxt = ST_XPREP;
      ST_XPREP: begin
        state_nxt = ST_XDIV;
        cnt_nxt   = '0;
      end
      ST_XDIV: begin
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_XDONE;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_XDONE: state_nxt = ST_YMUL;
      ST_YMUL:  state_nxt = ST_YPREP;
      ST_YPREP: begin
        state_nxt = ST_YDIV;
        cnt_nxt   = '0;
      end
      ST_YDIV: begin
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_YDONE;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_YDONE: state_nxt = ST_CMUL;
      ST_CMUL:  state_nxt = ST_DMUL;
      ST_DMUL:  state_nxt = ST_EMUL;
      ST_EMUL:  state_nxt = ST_COL;
      ST_COL:   state_nxt = ST_ROW;
      ST_ROW:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands and handshake outputs.
  always_comb begin
    cmd.step = cnt_r;
    cmd.op   = DP_NOP;
    unique case (state_r)
      ST_IDLE:   cmd.op = in_valid ? DP_LOAD : DP_NOP;
      ST_SQX:    cmd.op = DP_SQX;
      ST_SQY:    cmd.op = DP_SQY;
      ST_SQSUM:  cmd.op = DP_SQSUM;
      ST_SQRT:   cmd.op = DP_SQRT;
      ST_CHECK:  cmd.op = DP_CINIT;
      ST_CORDIC: cmd.op = DP_CORDIC;
      ST_HINIT:  cmd.op = DP_HINIT;
      ST_HMUL:   cmd.op = DP_HMUL;
      ST_HADD:   cmd.op = DP_HADD;
      ST_XMUL:   cmd.op = DP_XMUL;
      ST_XPREP:  cmd.op = DP_DPREP;
      ST_XDIV:   cmd.op = DP_DIV;
      ST_XDONE:  cmd.op = DP_XDONE;
      ST_YMUL:   cmd.op = DP_YMUL;
      ST_YPREP:  cmd.op = DP_DPREP;
      ST_YDIV:   cmd.op = DP_DIV;
      ST_YDONE:  cmd.op = DP_YDONE;
      ST_CMUL:   cmd.op = DP_CMUL;
      ST_DMUL:   cmd.op = DP_DMUL;
      ST_EMUL:   cmd.op = DP_EMUL;
      ST_COL:    cmd.op = DP_COL;
      ST_ROW:    cmd.op = DP_ROW;
      ST_DONE:   cmd.op = out_load ? DP_OUT : DP_NOP;
      default:   cmd.op = DP_NOP;
    endcase
  end

  // Result valid: set on load, cleared once taken.
  always_comb begin
    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- design/opp_dp.sv -----
// Datapath: coefficient store, shared multiplier, square root, CORDIC and divider.
module opp_dp #(
  parameter int COEFF_TERMS = opp_pkg::COEFF_TERMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  opp_pkg::dp_cmd_t  cmd,
  output opp_pkg::dp_stat_t stat,
  input  opp_pkg::opp_in_t  in_data,
  input  opp_pkg::opp_cfg_t cfg,
  output opp_pkg::opp_out_t out_data
);
  import opp_pkg::*;

  localparam int CIW = (COEFF_TERMS > 1) ? $clog2(COEFF_TERMS) : 1;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;
  localparam logic signed [65:0] HALF30  = 66'sd536870912;

  // Clamp a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7FFFFFFF;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  logic signed [31:0] coef_r [COEFF_TERMS];
  logic signed [31:0] x_r, y_r, z_r;
  logic signed [63:0] prod_r;
  logic [63:0]        rad_r;
  logic [33:0]        rem_r;
  logic [31:0]        norm_r;
  logic signed [35:0] xc_r, yc_r;
  logic signed [31:0] theta_r;
  logic signed [31:0] acc_r;
  logic [62:0]        dvd_r;
  logic [31:0]        drem_r;
  logic               neg_r;
  logic signed [31:0] xn_r, yn_r;
  logic signed [65:0] sum_r;
  logic signed [31:0] col_r, row_r;
  logic               vres_r;
  opp_out_t           out_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [35:0]        sq_sh, sq_trial;
  logic               sq_ge;
  logic [32:0]        dv_sh;
  logic               dv_ge;
  logic [4:0]         shamt;
  logic signed [35:0] cx_d, cy_d;
  logic signed [31:0] at;
  logic signed [63:0] hr;
  logic signed [65:0] hsum;
  logic signed [31:0] qsat_pos, qsat_neg, qsat;
  logic               qbig;
  logic signed [65:0] prod_w, col_w, row_w;
  logic signed [33:0] yrow;
  logic signed [32:0] ax, ay, aacc;

  assign ax   = x_r[31] ? -{x_r[31], x_r} : {x_r[31], x_r};
  assign ay   = y_r[31] ? -{y_r[31], y_r} : {y_r[31], y_r};
  assign aacc = acc_r[31] ? -{acc_r[31], acc_r} : {acc_r[31], acc_r};

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      DP_SQX:  begin mul_a = {x_r[31], x_r};     mul_b = {x_r[31], x_r}; end
      DP_SQY:  begin mul_a = {y_r[31], y_r};     mul_b = {y_r[31], y_r}; end
      DP_HMUL: begin mul_a = {acc_r[31], acc_r}; mul_b = {theta_r[31], theta_r}; end
      DP_XMUL: begin mul_a = ax;                 mul_b = aacc; end
      DP_YMUL: begin mul_a = ay;                 mul_b = aacc; end
      DP_CMUL: begin
        mul_a = {xn_r[31], xn_r};
        mul_b = {cfg.affine_c[31], cfg.affine_c};
      end
      DP_DMUL: begin
        mul_a = {yn_r[31], yn_r};
        mul_b = {cfg.affine_d[31], cfg.affine_d};
      end
      DP_EMUL: begin
        mul_a = {xn_r[31], xn_r};
        mul_b = {cfg.affine_e[31], cfg.affine_e};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // One square-root digit: bring down two radicand bits, try 4*res+1.
  assign sq_sh    = {rem_r, rad_r[63:62]};
  assign sq_trial = {2'b00, norm_r, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  // One restoring division step.
  assign dv_sh = {drem_r, dvd_r[62]};
  assign dv_ge = (dv_sh >= {1'b0, norm_r});

  // One CORDIC vectoring step.
  assign shamt = cmd.step[4:0];
  assign cx_d  = yc_r >>> shamt;
  assign cy_d  = xc_r >>> shamt;
  assign at    = $signed(atan_f(shamt));

  // Horner update: round the Q2.30 product, add the coefficient.
  assign hr   = prod_r + 64'sd536870912;
  assign hsum = ($signed({{2{hr[63]}}, hr}) >>> 30)
              + $signed({{34{coef_r[cmd.step[CIW-1:0]][31]}}, coef_r[cmd.step[CIW-1:0]]});

  // Quotient sign and saturation.
  assign qbig     = |dvd_r[62:31];
  assign qsat_pos = qbig ? 32'sh7FFFFFFF : $signed(dvd_r[31:0]);
  assign qsat_neg = qbig ? 32'sh80000000 : -$signed(dvd_r[31:0]);
  assign qsat     = neg_r ? qsat_neg : qsat_pos;

  // Affine sums.
  assign prod_w = $signed({{2{prod_r[63]}}, prod_r});
  assign col_w  = ((sum_r + $signed({8'b0, cfg.center_col, 29'b0}) + HALF30) >>> 30);
  assign yrow   = $signed({{2{yn_r[31]}}, yn_r}) + $signed({5'b0, cfg.center_row});
  assign row_w  = ((sum_r + HALF30) >>> 30);

  // Coefficient store, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COEFF_TERMS; i++) coef_r[i] <= '0;
    end else if (cmd.op == DP_LOAD && in_data.op == OP_LOAD &&
                 32'(in_data.coef_index) < COEFF_TERMS) begin
      coef_r[in_data.coef_index[CIW-1:0]] <= in_data.coef_value;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        x_r <= in_data.point_x;
        y_r <= in_data.point_y;
        z_r <= in_data.point_z;
      end
      DP_SQX: prod_r <= mul_p[63:0];
      DP_SQY: begin
        rad_r  <= prod_r;
        prod_r <= mul_p[63:0];
      end
      DP_SQSUM: begin
        rad_r  <= rad_r + prod_r;
        rem_r  <= '0;
        norm_r <= '0;
      end
      DP_SQRT: begin
        rad_r  <= {rad_r[61:0], 2'b00};
        rem_r  <= sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
        norm_r <= {norm_r[30:0], sq_ge};
      end
      DP_CINIT: begin
        xc_r    <= $signed({4'b0, norm_r});
        yc_r    <= -$signed({{4{z_r[31]}}, z_r});
        theta_r <= '0;
        vres_r  <= (norm_r != '0);
        col_r   <= '0;
        row_r   <= '0;
      end
      DP_CORDIC: begin
        if (!yc_r[35]) begin
          xc_r    <= xc_r + cx_d;
          yc_r    <= yc_r - cy_d;
          theta_r <= theta_r + at;
        end else begin
          xc_r    <= xc_r - cx_d;
          yc_r    <= yc_r + cy_d;
          theta_r <= theta_r - at;
        end
      end
      DP_HINIT: acc_r <= coef_r[COEFF_TERMS-1];
      DP_HMUL:  prod_r <= mul_p[63:0];
      DP_HADD:  acc_r <= sat32(hsum);
      DP_XMUL: begin
        prod_r <= mul_p[63:0];
        neg_r  <= x_r[31] ^ acc_r[31];
      end
      DP_YMUL: begin
        prod_r <= mul_p[63:0];
        neg_r  <= y_r[31] ^ acc_r[31];
      end
      DP_DPREP: begin
        dvd_r  <= prod_r[62:0] + {32'b0, norm_r[31:1]};
        drem_r <= '0;
      end
      DP_DIV: begin
        drem_r <= dv_ge ? 32'(dv_sh - {1'b0, norm_r}) : dv_sh[31:0];
        dvd_r  <= {dvd_r[61:0], dv_ge};
      end
      DP_XDONE: xn_r <= qsat;
      DP_YDONE: yn_r <= qsat;
      DP_CMUL:  prod_r <= mul_p[63:0];
      DP_DMUL: begin
        prod_r <= mul_p[63:0];
        sum_r  <= prod_w >>> 1;
      end
      DP_EMUL: begin
        prod_r <= mul_p[63:0];
        sum_r  <= sum_r + (prod_w >>> 1);
      end
      DP_COL: begin
        col_r <= sat32(col_w);
        sum_r <= prod_w + $signed({{2{yrow[33]}}, yrow, 30'b0});
      end
      DP_ROW: row_r <= sat32(row_w);
      DP_OUT: begin
        out_r.pixel_col <= col_r;
        out_r.pixel_row <= row_r;
        out_r.valid_res <= vres_r;
      end
      default: ;
    endcase
  end

  assign stat.norm_zero = (norm_r == '0);
  assign out_data       = out_r;

endmodule

// ----- design/omni_point_to_pixel_projection.sv -----
// Top level of the omnidirectional point-to-pixel projection block.
//
//  channel  direction  handshake                  payload
//  in_      request    in_valid / in_stall        opp_in_t (load or project)
//  out_     result     out_valid / out_stall      opp_out_t (one per project)
//  cfg      register   psel/penable/pwrite/pready affine terms and image center
//
// A load request is taken in the idle state and leaves the block free. A project request
// runs the one-bit-per-cycle square root (32 steps), the CORDIC and Horner stages, and the
// two 63-step divisions on the shared restoring divider; a point on the optical axis goes
// from the square root check straight to the result.
// Reset is synchronous and active low; it clears the coefficient store at once.
// A finished result waits in the output register while the next request is taken.
module omni_point_to_pixel_projection #(
  parameter int COEFF_TERMS      = opp_pkg::COEFF_TERMS_DEF,
  parameter int ANGLE_ITERATIONS = opp_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  opp_pkg::opp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output opp_pkg::opp_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import opp_pkg::*;

  opp_cfg_t    cfg_r;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.affine_c   <= 32'sh40000000;
      cfg_r.affine_d   <= '0;
      cfg_r.affine_e   <= '0;
      cfg_r.center_col <= '0;
      cfg_r.center_row <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_AFFINE_C:   cfg_r.affine_c   <= pwdata;
        REG_AFFINE_D:   cfg_r.affine_d   <= pwdata;
        REG_AFFINE_E:   cfg_r.affine_e   <= pwdata;
        REG_CENTER_COL: cfg_r.center_col <= pwdata[28:0];
        REG_CENTER_ROW: cfg_r.center_row <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_AFFINE_C:   prdata = cfg_r.affine_c;
      REG_AFFINE_D:   prdata = cfg_r.affine_d;
      REG_AFFINE_E:   prdata = cfg_r.affine_e;
      REG_CENTER_COL: prdata = {3'b0, cfg_r.center_col};
      REG_CENTER_ROW: prdata = {3'b0, cfg_r.center_row};
      default:        prdata = '0;
    endcase
  end

  opp_ctrl #(
    .COEFF_TERMS      (COEFF_TERMS),
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  opp_dp #(
    .COEFF_TERMS (COEFF_TERMS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // A project request occupies the block on the following cycle.
  a_project_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op == OP_PROJECT) |=> in_stall)
    else $error("project request did not occupy the block");

  // A load request leaves the block free for the next request.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op == OP_LOAD) |=> !in_stall)
    else $error("load request stalled the input");

  // An on-axis result carries zero coordinates.
  a_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.valid_res) |->
      (out_data.pixel_col == '0 && out_data.pixel_row == '0))
    else $error("on-axis result with nonzero pixel");

  // A write to the stretch term lands in its register.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && reg_idx == REG_AFFINE_C) |=> (cfg_r.affine_c == $past(pwdata)))
    else $error("affine_c write lost");
`endif

endmodule
